// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the key debounce RTL.
// Each macro expects signals named clk and rst_n in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge outside reset
`define KDB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition leads to a consequence in the next cycle
`define KDB_ASSERT_NEXT(lbl, ante, cons, msg) \
  `KDB_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

// ----- hdl/kdb_pkg.sv -----
// Package for the key debounce block: command, phase and event codes,
// register indexes, reset values and the structs shared between modules.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package kdb_pkg;

  localparam int NUM_KEYS     = 5;
  localparam int NUM_SWITCHES = 2;
  localparam int CFG_W        = 16;
  localparam int CFG_IDX_W    = 1;

  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS = 1'd1;

  localparam logic [CFG_W-1:0] DEBOUNCE_RESET = 16'd4;
  localparam int               LONG_FACTOR    = 100;
  localparam logic [CFG_W-1:0] LONG_RESET     = CFG_W'(4 * LONG_FACTOR);

  typedef enum logic [1:0] {
    CMD_TICK = 2'd0,
    CMD_SCAN = 2'd1,
    CMD_ACK  = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_DEBOUNCE = 2'd1,
    PH_HELD     = 2'd2,
    PH_WAIT     = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_SHORT = 2'd1,
    EV_LONG  = 2'd2
  } event_t;

  // Command broadcast to every lane and the result stage
  typedef struct packed {
    logic accept;
    cmd_t cmd;
  } lane_ctl_t;

  // Tick limits from the configuration registers
  typedef struct packed {
    logic [CFG_W-1:0] debounce;
    logic [CFG_W-1:0] long_press;
  } limits_t;

endpackage

`default_nettype wire

// ----- hdl/key_debounce_short_long_press.sv -----
// Top level of the key debounce block: configuration registers, one lane per
// key and the result stage. Depends on kdb_pkg, kdb_lane and kdb_merge.
//
//   channel | direction | handshake              | payload
//   in_     | input     | in_valid / in_ready    | cmd, key_levels, switch_levels, clear_mask
//   out_    | output    | out_valid / out_ready  | event_key0..4, switch_on0..1
//   cfg_    | input     | cfg_we (no wait)       | cfg_index, cfg_wdata
//
// All key lanes update in parallel at the accept edge, and the result is
// loaded into the output register at that same edge.
// One item per cycle is sustained while out_ready stays high; the single
// output register stalls the input only when its result is not taken.
// rst_n is synchronous: phases idle, timers zero, events cleared, switches off,
// debounce limit 4 and long-press limit 400.
`timescale 1ns / 1ps
`default_nettype none

module key_debounce_short_long_press
  import kdb_pkg::*;
#(
  parameter int TIMER_BITS = 16
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic [1:0]              in_cmd,
  input  wire logic [NUM_KEYS-1:0]     in_key_levels,
  input  wire logic [NUM_SWITCHES-1:0] in_switch_levels,
  input  wire logic [NUM_KEYS-1:0]     in_clear_mask,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic [1:0]                   out_event_key0,
  output logic [1:0]                   out_event_key1,
  output logic [1:0]                   out_event_key2,
  output logic [1:0]                   out_event_key3,
  output logic [1:0]                   out_event_key4,
  output logic                         out_switch_on0,
  output logic                         out_switch_on1,
  input  wire logic                    cfg_we,
  input  wire logic [CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [CFG_W-1:0]        cfg_wdata
);

  logic [CFG_W-1:0]        debounce_r, debounce_nxt;
  logic [CFG_W-1:0]        long_r, long_nxt;
  lane_ctl_t               ctl;
  limits_t                 limits;
  event_t                  ev_nxt [NUM_KEYS];
  event_t                  ev_q [NUM_KEYS];
  logic [NUM_SWITCHES-1:0] sw_q;

  // Write configuration registers
  always_comb begin
    debounce_nxt = debounce_r;
    long_nxt     = long_r;
    if (cfg_we) begin
      if (cfg_index == REG_DEBOUNCE) begin
        debounce_nxt = cfg_wdata;
      end else if (cfg_index == REG_LONG_PRESS) begin
        long_nxt = cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r <= DEBOUNCE_RESET;
      long_r     <= LONG_RESET;
    end else begin
      debounce_r <= debounce_nxt;
      long_r     <= long_nxt;
    end
  end

  assign ctl.accept        = in_valid && in_ready;
  assign ctl.cmd           = cmd_t'(in_cmd);
  assign limits.debounce   = debounce_r;
  assign limits.long_press = long_r;

  // One lane per key
  for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
    kdb_lane #(
      .TIMER_BITS (TIMER_BITS)
    ) u_lane (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .limits    (limits),
      .key_high  (in_key_levels[k]),
      .clear     (in_clear_mask[k]),
      .event_nxt (ev_nxt[k])
    );
  end

  kdb_merge u_merge (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctl           (ctl),
    .switch_levels (in_switch_levels),
    .ev_nxt        (ev_nxt),
    .out_ready     (out_ready),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .ev_q          (ev_q),
    .sw_q          (sw_q)
  );

  // Unpack the result onto the field ports
  assign out_event_key0 = ev_q[0];
  assign out_event_key1 = ev_q[1];
  assign out_event_key2 = ev_q[2];
  assign out_event_key3 = ev_q[3];
  assign out_event_key4 = ev_q[4];
  assign out_switch_on0 = sw_q[0];
  assign out_switch_on1 = sw_q[1];

endmodule

`default_nettype wire

// ----- hdl/kdb_lane.sv -----
// One key lane: phase machine, tick timer and posted event of a single key.
// Depends on kdb_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module kdb_lane
  import kdb_pkg::*;
#(
  parameter int TIMER_BITS = 16
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire lane_ctl_t ctl,
  input  wire limits_t   limits,
  input  wire logic      key_high,
  input  wire logic      clear,
  output event_t         event_nxt
);

  localparam int CMP_W = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;

  phase_t                phase_r, phase_nxt;
  logic [TIMER_BITS-1:0] timer_r, timer_nxt;
  event_t                event_r;
  logic [CMP_W-1:0]      timer_ext, debounce_ext, long_ext;

  assign timer_ext    = CMP_W'(timer_r);
  assign debounce_ext = CMP_W'(limits.debounce);
  assign long_ext     = CMP_W'(limits.long_press);

  // Hold lane state, clear on reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      timer_r <= '0;
      event_r <= EV_NONE;
    end else begin
      phase_r <= phase_nxt;
      timer_r <= timer_nxt;
      event_r <= event_nxt;
    end
  end

  // Advance the phase machine for the accepted item
  always_comb begin
    phase_nxt = phase_r;
    timer_nxt = timer_r;
    event_nxt = event_r;
    if (ctl.accept) begin
      unique case (ctl.cmd)
        CMD_TICK: begin
          // a wrapped timer stays at zero
          if (timer_r != '0) begin
            timer_nxt = timer_r + TIMER_BITS'(1);
          end
        end
        CMD_SCAN: begin
          unique case (phase_r)
            PH_IDLE: begin
              if (!key_high) begin
                phase_nxt = PH_DEBOUNCE;
                timer_nxt = TIMER_BITS'(1);
              end
            end
            PH_DEBOUNCE: begin
              if (timer_ext > debounce_ext && !key_high) begin
                phase_nxt = PH_HELD;
              end
            end
            PH_HELD: begin
              if (key_high) begin
                phase_nxt = PH_IDLE;
                event_nxt = EV_SHORT;
              end else if (timer_ext > long_ext) begin
                phase_nxt = PH_WAIT;
                event_nxt = EV_LONG;
              end
            end
            PH_WAIT: begin
              if (key_high) begin
                phase_nxt = PH_IDLE;
                event_nxt = EV_NONE;
              end
            end
            default: begin
              phase_nxt = phase_r;
            end
          endcase
        end
        CMD_ACK: begin
          if (clear) begin
            event_nxt = EV_NONE;
          end
        end
        default: begin
          phase_nxt = phase_r;
        end
      endcase
    end
  end

  `KDB_ASSERT_NEXT(a_timer_stays_stopped,
    timer_r == '0 && !(ctl.accept && ctl.cmd == CMD_SCAN && phase_r == PH_IDLE),
    timer_r == '0, "lane timer left zero without a press in idle")
  `KDB_ASSERT_NEXT(a_ack_clears_event, ctl.accept && ctl.cmd == CMD_ACK && clear,
    event_r == EV_NONE, "acknowledged event not cleared")
  `KDB_ASSERT_NEXT(a_tick_keeps_phase, ctl.accept && ctl.cmd == CMD_TICK,
    phase_r == $past(phase_r), "tick changed the key phase")

endmodule

`default_nettype wire

// ----- hdl/kdb_merge.sv -----
// Result stage: gathers the lane events and switch state into the output
// register and runs the result handshake. Depends on kdb_pkg, assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module kdb_merge
  import kdb_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire lane_ctl_t               ctl,
  input  wire logic [NUM_SWITCHES-1:0] switch_levels,
  input  wire event_t                  ev_nxt [NUM_KEYS],
  input  wire logic                    out_ready,
  output logic                         in_ready,
  output logic                         out_valid,
  output event_t                       ev_q [NUM_KEYS],
  output logic [NUM_SWITCHES-1:0]      sw_q
);

  logic                    out_valid_r, out_valid_nxt;
  logic [NUM_SWITCHES-1:0] switch_r, switch_nxt;
  event_t                  ev_r [NUM_KEYS];
  logic [NUM_SWITCHES-1:0] sw_r;

  // Take a new item whenever the output register is empty or draining
  assign in_ready  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign ev_q      = ev_r;
  assign sw_q      = sw_r;

  // Sample inverted switch levels on a scan
  always_comb begin
    switch_nxt = switch_r;
    if (ctl.accept && ctl.cmd == CMD_SCAN) begin
      switch_nxt = ~switch_levels;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctl.accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      switch_r    <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      switch_r    <= switch_nxt;
    end
  end

  // Load the result payload on an accepted item
  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      ev_r <= ev_nxt;
      sw_r <= switch_nxt;
    end
  end

  `KDB_ASSERT_NEXT(a_accept_gives_result, ctl.accept, out_valid_r,
    "accepted item produced no result")
  `KDB_ASSERT_NEXT(a_drained_goes_empty, !ctl.accept && out_valid_r && out_ready,
    !out_valid_r, "result repeated after being taken")
  `KDB_ASSERT_NEXT(a_scan_loads_switches, ctl.accept && ctl.cmd == CMD_SCAN,
    sw_r == ~$past(switch_levels), "scan did not report inverted switch levels")

endmodule

`default_nettype wire
